@@ rtl/core/shs_pkg.sv @@
`default_nettype none

package shs_pkg;

    // eight 32-bit words, index 0 is a / H0
    typedef logic [7:0][31:0] word_arr_t;

    // sequencer states
    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_ROUND = 5'b00010,
        ST_FINAL = 5'b00100,
        ST_PAD   = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

    // control from sequencer to the message window
    typedef struct packed {
        logic       push;
        logic       step;
        logic [7:0] data;
    } win_ctrl_t;

    // control from sequencer to the round unit
    typedef struct packed {
        logic       load;
        logic       step;
        logic [5:0] round;
    } round_ctrl_t;

    localparam logic [7:0] PAD_MARKER = 8'h80;
    localparam logic [5:0] LEN_OFFSET = 6'd56;
    localparam logic [5:0] LAST_ROUND = 6'd63;
    localparam logic [5:0] LAST_FILL  = 6'd63;
    localparam logic [2:0] LAST_IDX   = 3'd7;

    // initial hash values, H7 first in the concatenation
    localparam word_arr_t INIT_HASH = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    // round constants
    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // big sigma 0 on a
    function automatic logic [31:0] bsig0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    // big sigma 1 on e
    function automatic logic [31:0] bsig1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    // small sigma 0 for the schedule
    function automatic logic [31:0] ssig0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    // small sigma 1 for the schedule
    function automatic logic [31:0] ssig1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/shs_msg_window.sv @@
`default_nettype none

module shs_msg_window
    import shs_pkg::*;
(
    input  wire logic        clk,
    input  wire win_ctrl_t   ctrl,
    output logic [31:0]      w_cur
);

    logic [31:0] win_reg  [16];
    logic [31:0] win_next [16];
    logic [31:0] sched_new;

    // next schedule word from the sixteen-word window
    assign sched_new = ssig1(win_reg[14]) + win_reg[9] + ssig0(win_reg[1]) + win_reg[0];
    assign w_cur     = win_reg[0];

    // byte packing shifts big-endian, round stepping shifts one word
    always_comb
    begin
        win_next = win_reg;
        if (ctrl.push)
        begin
            for (int k = 0; k < 15; k++)
            begin
                win_next[k] = {win_reg[k][23:0], win_reg[k + 1][31:24]};
            end
            win_next[15] = {win_reg[15][23:0], ctrl.data};
        end
        else if (ctrl.step)
        begin
            for (int k = 0; k < 15; k++)
            begin
                win_next[k] = win_reg[k + 1];
            end
            win_next[15] = sched_new;
        end
    end

    // window storage
    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
    end

endmodule

`default_nettype wire

@@ rtl/core/shs_round_unit.sv @@
`default_nettype none

module shs_round_unit
    import shs_pkg::*;
(
    input  wire logic        clk,
    input  wire round_ctrl_t ctrl,
    input  wire word_arr_t   chain,
    input  wire logic [31:0] w_cur,
    output word_arr_t        vars
);

    word_arr_t   vars_reg;
    word_arr_t   vars_next;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] ch;
    logic [31:0] maj;

    // round function on a..h
    assign ch  = (vars_reg[4] & vars_reg[5]) ^ (~vars_reg[4] & vars_reg[6]);
    assign maj = (vars_reg[0] & vars_reg[1]) ^ (vars_reg[0] & vars_reg[2])
               ^ (vars_reg[1] & vars_reg[2]);
    assign t1  = vars_reg[7] + bsig1(vars_reg[4]) + ch + ROUND_K[ctrl.round] + w_cur;
    assign t2  = bsig0(vars_reg[0]) + maj;

    always_comb
    begin
        vars_next = vars_reg;
        if (ctrl.load)
        begin
            vars_next = chain;
        end
        else if (ctrl.step)
        begin
            vars_next[7] = vars_reg[6];
            vars_next[6] = vars_reg[5];
            vars_next[5] = vars_reg[4];
            vars_next[4] = vars_reg[3] + t1;
            vars_next[3] = vars_reg[2];
            vars_next[2] = vars_reg[1];
            vars_next[1] = vars_reg[0];
            vars_next[0] = t1 + t2;
        end
    end

    // working variables
    always_ff @(posedge clk)
    begin
        vars_reg <= vars_next;
    end

    assign vars = vars_reg;

endmodule

`default_nettype wire

@@ rtl/core/sha256_stream_hasher_unit.sv @@
// input: each accepted byte word goes into the block buffer; a full block then runs
// through the rounds in the shared round unit, then the chaining add.
// end of message: 9 to 72 padding bytes one by one and one or two compressions,
// then eight digest words, one per cycle while out_ready is high.
// in_ready is high only in idle: no byte is taken during rounds, padding or output.
// reset (rst_n low, asynchronous): initial hash loaded, length and fill cleared, idle.
`default_nettype none

module sha256_stream_hasher_unit
    import shs_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic        byte_present,
    input  wire logic        end_of_message,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      digest_word,
    output logic [2:0]       word_index,
    output logic             last_word
);

    state_t      state_reg, state_next;
    word_arr_t   chain_reg, chain_next;
    logic [63:0] len_reg, len_next;
    logic [5:0]  fill_reg, fill_next;
    logic [5:0]  round_reg, round_next;
    logic        pad_active_reg, pad_active_next;
    logic        marker_done_reg, marker_done_next;
    logic        pad_done_reg, pad_done_next;
    logic [2:0]  len_idx_reg, len_idx_next;
    logic [2:0]  out_idx_reg, out_idx_next;

    logic [7:0][7:0] len_octets;
    logic            in_acc;
    logic            out_acc;
    logic            len_phase;
    win_ctrl_t       win_ctrl;
    round_ctrl_t     round_ctrl;
    logic [31:0]     w_cur;
    word_arr_t       vars;

    assign len_octets = len_reg;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign in_acc    = in_valid && in_ready;
    assign out_acc   = out_valid && out_ready;
    assign len_phase = (fill_reg == LEN_OFFSET) || (len_idx_reg != 3'd0);

    // digest words straight from the chaining registers
    assign digest_word = chain_reg[out_idx_reg];
    assign word_index  = out_idx_reg;
    assign last_word   = (out_idx_reg == LAST_IDX);

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        chain_next       = chain_reg;
        len_next         = len_reg;
        fill_next        = fill_reg;
        round_next       = round_reg;
        pad_active_next  = pad_active_reg;
        marker_done_next = marker_done_reg;
        pad_done_next    = pad_done_reg;
        len_idx_next     = len_idx_reg;
        out_idx_next     = out_idx_reg;
        win_ctrl         = '0;
        round_ctrl       = '0;
        round_ctrl.round = round_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (byte_present)
                    begin
                        win_ctrl.push = 1'b1;
                        win_ctrl.data = data_byte;
                        len_next      = len_reg + 64'd8;
                        fill_next     = fill_reg + 6'd1;
                    end
                    if (byte_present && (fill_reg == LAST_FILL))
                    begin
                        state_next      = ST_ROUND;
                        round_ctrl.load = 1'b1;
                        round_next      = 6'd0;
                        pad_active_next = end_of_message;
                    end
                    else if (end_of_message)
                    begin
                        state_next      = ST_PAD;
                        pad_active_next = 1'b1;
                    end
                end
            end

            ST_ROUND:
            begin
                round_ctrl.step = 1'b1;
                win_ctrl.step   = 1'b1;
                round_next      = round_reg + 6'd1;
                if (round_reg == LAST_ROUND)
                begin
                    state_next = ST_FINAL;
                end
            end

            ST_FINAL:
            begin
                for (int k = 0; k < 8; k++)
                begin
                    chain_next[k] = chain_reg[k] + vars[k];
                end
                if (pad_done_reg)
                begin
                    state_next = ST_OUT;
                end
                else if (pad_active_reg)
                begin
                    state_next = ST_PAD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_PAD:
            begin
                // marker, then zeros up to the length field, then the bit count
                win_ctrl.push = 1'b1;
                fill_next     = fill_reg + 6'd1;
                if (!marker_done_reg)
                begin
                    win_ctrl.data    = PAD_MARKER;
                    marker_done_next = 1'b1;
                end
                else if (len_phase)
                begin
                    win_ctrl.data = len_octets[LAST_IDX - len_idx_reg];
                    len_idx_next  = len_idx_reg + 3'd1;
                    if (len_idx_reg == LAST_IDX)
                    begin
                        pad_done_next = 1'b1;
                    end
                end
                else
                begin
                    win_ctrl.data = 8'h00;
                end
                if (fill_reg == LAST_FILL)
                begin
                    state_next      = ST_ROUND;
                    round_ctrl.load = 1'b1;
                    round_next      = 6'd0;
                end
            end

            ST_OUT:
            begin
                if (out_acc)
                begin
                    out_idx_next = out_idx_reg + 3'd1;
                    if (out_idx_reg == LAST_IDX)
                    begin
                        state_next       = ST_IDLE;
                        chain_next       = INIT_HASH;
                        len_next         = 64'd0;
                        fill_next        = 6'd0;
                        pad_active_next  = 1'b0;
                        marker_done_next = 1'b0;
                        pad_done_next    = 1'b0;
                        len_idx_next     = 3'd0;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            chain_reg       <= INIT_HASH;
            len_reg         <= 64'd0;
            fill_reg        <= 6'd0;
            round_reg       <= 6'd0;
            pad_active_reg  <= 1'b0;
            marker_done_reg <= 1'b0;
            pad_done_reg    <= 1'b0;
            len_idx_reg     <= 3'd0;
            out_idx_reg     <= 3'd0;
        end
        else
        begin
            state_reg       <= state_next;
            chain_reg       <= chain_next;
            len_reg         <= len_next;
            fill_reg        <= fill_next;
            round_reg       <= round_next;
            pad_active_reg  <= pad_active_next;
            marker_done_reg <= marker_done_next;
            pad_done_reg    <= pad_done_next;
            len_idx_reg     <= len_idx_next;
            out_idx_reg     <= out_idx_next;
        end
    end

    // block buffer and message schedule
    shs_msg_window u_window (
        .clk   (clk),
        .ctrl  (win_ctrl),
        .w_cur (w_cur)
    );

    // shared round unit
    shs_round_unit u_round (
        .clk   (clk),
        .ctrl  (round_ctrl),
        .chain (chain_reg),
        .w_cur (w_cur),
        .vars  (vars)
    );

endmodule

`default_nettype wire

@@ rtl/core/shs_checker.sv @@
`default_nettype none

module shs_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [31:0] digest_word,
    input wire logic [2:0]  word_index,
    input wire logic        last_word
);

    // a stalled digest word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(digest_word) && $stable(word_index))
        else $error("digest word changed while stalled");

    // the block never takes input while a digest is pending
    assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input ready during digest output");

    // last flag marks the eighth word
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last_word == (word_index == 3'd7)))
        else $error("last word flag out of step with index");

    // digest words come back to back in order
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_word
        |=> out_valid && (word_index == 3'($past(word_index) + 3'd1)))
        else $error("digest word sequence broken");

endmodule

bind sha256_stream_hasher_unit shs_checker u_shs_checker (.*);

`default_nettype wire

@@ verif/tb_sha256_stream_hasher_unit.sv @@
`timescale 1ns / 100ps

module tb_sha256_stream_hasher_unit;
    import shs_pkg::*;

    localparam int unsigned STALL_LIMIT  = 4000;
    localparam int unsigned TARGET_ITEMS = 360;
    localparam int unsigned SETTLE_CYCLES = 200;

    // one expected digest word
    typedef struct packed {
        logic [31:0] value;
        logic [2:0]  idx;
        logic        last;
    } digest_entry_t;

    // running hash of the byte stream and the digest words still owed
    class sha256_digest_board;
        bit [31:0]     chain [8];
        bit [7:0]      blk [64];
        int unsigned   fill;
        bit [63:0]     bit_len;
        digest_entry_t pending [$];
        int unsigned   mismatches;
        int unsigned   words_checked;
        int unsigned   messages;

        function new();
            mismatches = 0;
            words_checked = 0;
            messages = 0;
            restart();
        endfunction

        // back to the initial hash values for a fresh message
        function void restart();
            foreach (chain[k])
                chain[k] = INIT_HASH[k];
            fill = 0;
            bit_len = '0;
        endfunction

        function bit [31:0] rotr(bit [31:0] x, int unsigned n);
            return (x >> n) | (x << (32 - n));
        endfunction

        // full 64-round compression of the buffered block
        function void compress();
            bit [31:0] w [64];
            bit [31:0] a, b, c, d, e, f, g, h;
            bit [31:0] t1, t2, s0, s1;
            for (int r = 0; r < 16; r++)
                w[r] = {blk[4*r], blk[4*r+1], blk[4*r+2], blk[4*r+3]};
            for (int r = 16; r < 64; r++)
            begin
                s0 = rotr(w[r-15], 7) ^ rotr(w[r-15], 18) ^ (w[r-15] >> 3);
                s1 = rotr(w[r-2], 17) ^ rotr(w[r-2], 19) ^ (w[r-2] >> 10);
                w[r] = w[r-16] + s0 + w[r-7] + s1;
            end
            a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
            e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
            for (int r = 0; r < 64; r++)
            begin
                t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
                     + ROUND_K[r] + w[r];
                t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
                h = g; g = f; f = e; e = d + t1;
                d = c; c = b; b = a; a = t1 + t2;
            end
            chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
            chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
        endfunction

        function void push_byte(bit [7:0] v);
            blk[fill] = v;
            fill = (fill + 1) % 64;
            if (fill == 0)
                compress();
        endfunction

        // account for one accepted input word, queue the digest on message end
        function void take_item(bit [7:0] data, bit present, bit eom);
            bit [63:0] total;
            digest_entry_t ent;
            if (present)
            begin
                bit_len += 64'd8;
                push_byte(data);
            end
            if (!eom)
                return;
            total = bit_len;
            push_byte(PAD_MARKER);
            while (fill != int'(LEN_OFFSET))
                push_byte(8'h00);
            for (int k = 0; k < 8; k++)
                push_byte(total[63 - 8*k -: 8]);
            for (int k = 0; k < 8; k++)
            begin
                ent.value = chain[k];
                ent.idx   = k[2:0];
                ent.last  = (k[2:0] == LAST_IDX);
                pending.push_back(ent);
            end
            messages++;
            restart();
        endfunction

        task report_mismatch(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            mismatches++;
        endtask

        // compare one delivered digest word with the oldest one owed
        task check_word(bit [31:0] value, bit [2:0] idx, bit last);
            digest_entry_t want;
            if (pending.size() == 0)
            begin
                report_mismatch($sformatf("unexpected digest word %h index %0d", value, idx));
                return;
            end
            want = pending.pop_front();
            words_checked++;
            if (value != want.value)
                report_mismatch($sformatf("digest_word %h, wanted %h (index %0d)",
                                          value, want.value, want.idx));
            if (idx != want.idx)
                report_mismatch($sformatf("word_index %0d, wanted %0d", idx, want.idx));
            if (last != want.last)
                report_mismatch($sformatf("last_word %0b, wanted %0b (index %0d)",
                                          last, want.last, want.idx));
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte = 8'h00;
    logic        byte_present = 1'b0;
    logic        end_of_message = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    sha256_digest_board board;
    bit          calm = 1'b0;
    int unsigned payload_items = 0;
    int unsigned noise_items = 0;
    int unsigned idle_cycles = 0;

    sha256_stream_hasher_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .byte_present   (byte_present),
        .end_of_message (end_of_message),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .digest_word    (digest_word),
        .word_index     (word_index),
        .last_word      (last_word)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // digest side: random back-pressure, check every accepted word
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                board.check_word(digest_word, word_index, last_word);
            out_ready <= calm || ($urandom_range(99) >= 20);
        end
    end

    // stall watchdog
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no word moved for %0d cycles", idle_cycles);
            $display("[FAIL] regression broken");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // offer one input word and hold it until taken
    task send_item(input logic [7:0] d, input bit p, input bit e);
        int unsigned gap;
        gap = 0;
        if (!calm && $urandom_range(99) < 20)
            gap = $urandom_range(3, 1);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        data_byte      <= d;
        byte_present   <= p;
        end_of_message <= e;
        do
            @(posedge clk);
        while (!in_ready);
        board.take_item(d, p, e);
        if (p || e)
            payload_items++;
        else
            noise_items++;
    endtask

    // hold off the input until every owed digest word has come out
    task drain_digests();
        in_valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
    endtask

    // one whole message with random length and content, idle words mixed in
    task send_message();
        int unsigned len;
        int unsigned fill_kind;
        bit          eom_on_byte;
        logic [7:0]  v;
        case ($urandom_range(9))
            0: len = $urandom_range(2);
            1: len = 55;
            2: len = 56;
            3: len = $urandom_range(65, 63);
            4: len = ($urandom_range(3) == 0) ? $urandom_range(130, 118) : $urandom_range(57, 54);
            default: len = $urandom_range(24, 1);
        endcase
        fill_kind = $urandom_range(5);
        eom_on_byte = (len > 0) && ($urandom_range(1) == 1);
        for (int unsigned i = 0; i < len; i++)
        begin
            if ($urandom_range(9) == 0)
                send_item(8'($urandom_range(255)), 1'b0, 1'b0);
            case (fill_kind)
                0: v = 8'h00;
                1: v = 8'hff;
                default: v = 8'($urandom_range(255));
            endcase
            send_item(v, 1'b1, eom_on_byte && (i == len - 1));
        end
        if (!eom_on_byte)
            send_item(8'($urandom_range(255)), 1'b0, 1'b1);
    endtask

    initial
    begin
        bit drained_mid;
        drained_mid = 1'b0;
        board = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty message, idle words, single bytes at the extremes
        send_item(8'ha5, 1'b0, 1'b1);
        send_item(8'hff, 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'hff, 1'b1, 1'b1);
        // "abc" with the end flag on the last byte
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
        // end flag on a word without a byte after two bytes
        send_item(8'hff, 1'b1, 1'b0);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'h5a, 1'b0, 1'b1);
        // back-to-back empty message
        send_item(8'h00, 1'b0, 1'b1);
        drain_digests();

        // random messages, with one stretch free of input gaps and output back-pressure
        while (payload_items + noise_items < TARGET_ITEMS)
        begin
            calm = (payload_items >= 150) && (payload_items < 250);
            send_message();
            if (!drained_mid && payload_items >= 200)
            begin
                drain_digests();
                drained_mid = 1'b1;
            end
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("sent %0d message words and %0d idle words across %0d messages",
                 payload_items, noise_items, board.messages);
        $display("checked %0d digest words, %0d mismatches", board.words_checked,
                 board.mismatches);
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
